FILE: hw/rtl/dlr_pkg.sv
// dda line rasterizer package: field widths, register codes, reset values and item type
// no dependencies; used by the channel interfaces, dlr_front, dlr_back and the top module
`default_nettype none

package dlr_pkg;

  localparam int IN_BITS        = 16;
  localparam int COLOR_BITS     = 32;
  localparam int SIZE_BITS      = 13;
  localparam int PIX_BITS       = 12;
  localparam int SCALED_BITS    = 13;
  localparam int CFG_INDEX_BITS = 4;
  localparam int QUEUE_DEPTH    = 2;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = 4'd1;

  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd480;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [IN_BITS-1:0]    start_x;
    logic [IN_BITS-1:0]    start_y;
    logic [IN_BITS-1:0]    end_x;
    logic [IN_BITS-1:0]    end_y;
    logic [COLOR_BITS-1:0] line_color;
  } dlr_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dlr_in_if.sv
// request channel: valid/ready handshake with load or tick payload
// depends on dlr_pkg
`default_nettype none

interface dlr_in_if;
  import dlr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [IN_BITS-1:0]    start_x;
  logic [IN_BITS-1:0]    start_y;
  logic [IN_BITS-1:0]    end_x;
  logic [IN_BITS-1:0]    end_y;
  logic [COLOR_BITS-1:0] line_color;

  modport source (
    output valid, req_type, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );
  modport sink (
    input  valid, req_type, start_x, start_y, end_x, end_y, line_color,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/dlr_out_if.sv
// pixel channel: valid/ready handshake with one pixel per item
// depends on dlr_pkg
`default_nettype none

interface dlr_out_if;
  import dlr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PIX_BITS-1:0]   pixel_x;
  logic [PIX_BITS-1:0]   pixel_y;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/dlr_cfg_if.sv
// configuration write channel: register index and write data with valid/ready
// depends on dlr_pkg
`default_nettype none

interface dlr_cfg_if;
  import dlr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [SIZE_BITS-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dlr_div.sv
// restoring divider, one quotient bit per cycle, for the minor-axis slope
// depends on nothing but its parameters
`default_nettype none

module dlr_div #(
  parameter int NUM_BITS = 29,
  parameter int DEN_BITS = 13
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0] den,
  output logic                     done,
  output logic [NUM_BITS-1:0]      quot
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] sh;
  logic [DEN_BITS-1:0] rem;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;

  logic [DEN_BITS:0]   trial;
  logic                qbit;
  logic [DEN_BITS:0]   diff;

  assign trial = {rem, sh[NUM_BITS-1]};
  assign qbit  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};
  assign quot  = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(NUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= num;
      rem <= '0;
    end else if (busy) begin
      sh  <= {sh[NUM_BITS-2:0], qbit};
      rem <= qbit ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dlr_front.sv
// front end: accepts request items and queues them for the back end
// depends on dlr_pkg and dlr_in_if
`default_nettype none

module dlr_front (
  input  wire logic        clk,
  input  wire logic        rst,
  dlr_in_if.sink           in_ch,
  output dlr_pkg::dlr_item_t q_item,
  output logic             q_valid,
  input  wire logic        q_pop
);
  import dlr_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  dlr_item_t           slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  logic      push;
  logic      pop;
  dlr_item_t in_item;

  assign in_ch.ready = count != CNT_BITS'(QUEUE_DEPTH);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = count != '0;
  assign pop         = q_pop && q_valid;
  assign q_item      = slots[rd_ptr];

  // the one-bit request code decides load versus tick
  always_comb begin
    in_item.req_type   = in_ch.req_type ? REQ_TICK : REQ_LOAD;
    in_item.start_x    = in_ch.start_x;
    in_item.start_y    = in_ch.start_y;
    in_item.end_x      = in_ch.end_x;
    in_item.end_y      = in_ch.end_y;
    in_item.line_color = in_ch.line_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dlr_back.sv
// back end: scales endpoints, sets up the line through the divider, steps pixels
// depends on dlr_pkg, dlr_out_if and dlr_div
`default_nettype none

module dlr_back #(
  parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [dlr_pkg::SIZE_BITS-1:0] screen_width,
  input  wire logic [dlr_pkg::SIZE_BITS-1:0] screen_height,
  input  wire dlr_pkg::dlr_item_t            q_item,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  dlr_out_if.source                          out_ch
);
  import dlr_pkg::*;

  localparam int PROD_BITS  = IN_BITS + SIZE_BITS + 1;
  localparam int NUM_BITS   = SCALED_BITS + FRAC_BITS;
  localparam int QUOT_BITS  = FRAC_BITS + 1;
  localparam int SLOPE_BITS = FRAC_BITS + 2;
  localparam int ACC_BITS   = SCALED_BITS + FRAC_BITS + 2;
  localparam int MINOR_BITS = ACC_BITS - 1 - FRAC_BITS;

  localparam logic [SCALED_BITS:0]   CMAX_W    = (SCALED_BITS + 1)'((1 << COORD_BITS) - 1);
  localparam logic [PROD_BITS-1:0]   ROUND_IN  = PROD_BITS'(1 << (IN_BITS - 1));
  localparam logic [ACC_BITS-1:0]    ROUND_ACC = ACC_BITS'(1 << (FRAC_BITS - 1));

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCALE  = 3'd1;
  localparam logic [2:0] ST_SETUP  = 3'd2;
  localparam logic [2:0] ST_LAUNCH = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;

  logic [2:0] state;

  // line state
  logic                   line_active;
  logic                   major_is_x;
  logic                   major_step_negative;
  logic [SCALED_BITS-1:0] major_position;
  logic [ACC_BITS-1:0]    minor_accumulator;
  logic [SLOPE_BITS-1:0]  minor_slope;
  logic [SCALED_BITS-1:0] pixels_remaining;
  logic [COLOR_BITS-1:0]  held_color;

  // load setup
  dlr_item_t              ld;
  logic [1:0]             scale_idx;
  logic [SCALED_BITS-1:0] coord [4];
  logic [SCALED_BITS-1:0] n_len;
  logic [SCALED_BITS-1:0] minor_len;
  logic                   minor_neg;
  logic [SCALED_BITS-1:0] major_start;
  logic [SCALED_BITS-1:0] minor_start;

  // output register
  logic                  out_valid;
  logic [PIX_BITS-1:0]   out_x;
  logic [PIX_BITS-1:0]   out_y;
  logic [COLOR_BITS-1:0] out_color;
  logic                  out_last;

  logic                div_start;
  logic                div_done;
  logic [NUM_BITS-1:0] div_quot;
  logic [NUM_BITS-1:0] div_num;

  dlr_div #(
    .NUM_BITS (NUM_BITS),
    .DEN_BITS (SCALED_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (n_len),
    .done  (div_done),
    .quot  (div_quot)
  );

  // endpoint scaling, one coordinate per cycle through a single multiplier
  logic [IN_BITS-1:0]     v_sel;
  logic [SIZE_BITS-1:0]   s_sel;
  logic [SIZE_BITS-1:0]   s_eff;
  logic [PROD_BITS-1:0]   prod;
  logic [SCALED_BITS:0]   raw_c;
  logic [SCALED_BITS:0]   lim;
  logic [SCALED_BITS:0]   scaled;

  always_comb begin
    case (scale_idx)
      2'd0:    v_sel = ld.start_x;
      2'd1:    v_sel = ld.start_y;
      2'd2:    v_sel = ld.end_x;
      default: v_sel = ld.end_y;
    endcase
    s_sel  = scale_idx[0] ? screen_height : screen_width;
    s_eff  = (s_sel == '0) ? SIZE_BITS'(1) : s_sel;
    prod   = PROD_BITS'(v_sel) * PROD_BITS'(s_eff) + ROUND_IN;
    raw_c  = prod[PROD_BITS-1:IN_BITS];
    lim    = ({1'b0, s_eff - 1'b1} < CMAX_W) ? {1'b0, s_eff - 1'b1} : CMAX_W;
    scaled = (raw_c > lim) ? lim : raw_c;
  end

  // distances and major axis choice
  logic [SCALED_BITS:0]   dx;
  logic [SCALED_BITS:0]   dy;
  logic [SCALED_BITS-1:0] adx;
  logic [SCALED_BITS-1:0] ady;
  logic                   x_major;

  always_comb begin
    dx      = {1'b0, coord[2]} - {1'b0, coord[0]};
    dy      = {1'b0, coord[3]} - {1'b0, coord[1]};
    adx     = dx[SCALED_BITS] ? SCALED_BITS'(-dx) : dx[SCALED_BITS-1:0];
    ady     = dy[SCALED_BITS] ? SCALED_BITS'(-dy) : dy[SCALED_BITS-1:0];
    x_major = adx >= ady;
  end

  assign div_num = {minor_len, {FRAC_BITS{1'b0}}} + NUM_BITS'(n_len >> 1);

  // pixel step
  logic [ACC_BITS-1:0]    r_acc;
  logic [MINOR_BITS-1:0]  minor_raw;
  logic [MINOR_BITS-1:0]  minor_c;
  logic [SCALED_BITS-1:0] rem_dec;
  logic                   out_free;
  logic                   is_tick;
  logic                   emit;

  always_comb begin
    r_acc     = minor_accumulator + ROUND_ACC;
    minor_raw = r_acc[ACC_BITS-1] ? '0 : r_acc[ACC_BITS-2:FRAC_BITS];
    minor_c   = (minor_raw > MINOR_BITS'(CMAX_W)) ? MINOR_BITS'(CMAX_W) : minor_raw;
    rem_dec   = (pixels_remaining != '0) ? pixels_remaining - 1'b1 : '0;
    out_free  = !out_valid || out_ch.ready;
    is_tick   = q_item.req_type == REQ_TICK;
    emit      = (state == ST_IDLE) && q_valid && is_tick && line_active && out_free;
    q_pop     = (state == ST_IDLE) && q_valid &&
                (!is_tick || !line_active || out_free);
    div_start = (state == ST_LAUNCH) && (n_len != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      scale_idx           <= '0;
      line_active         <= 1'b0;
      major_is_x          <= 1'b0;
      major_step_negative <= 1'b0;
      major_position      <= '0;
      minor_accumulator   <= '0;
      minor_slope         <= '0;
      pixels_remaining    <= '0;
      held_color          <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (q_pop && !is_tick) begin
            state     <= ST_SCALE;
            scale_idx <= '0;
          end
          if (emit) begin
            pixels_remaining <= rem_dec;
            if (rem_dec == '0) begin
              line_active <= 1'b0;
            end else begin
              major_position <= major_step_negative ? major_position - 1'b1
                                                    : major_position + 1'b1;
              minor_accumulator <= minor_accumulator +
                {{(ACC_BITS - SLOPE_BITS){minor_slope[SLOPE_BITS-1]}}, minor_slope};
            end
          end
        end
        ST_SCALE: begin
          scale_idx <= scale_idx + 1'b1;
          if (scale_idx == 2'd3) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          major_is_x          <= x_major;
          major_step_negative <= x_major ? dx[SCALED_BITS] : dy[SCALED_BITS];
          state               <= ST_LAUNCH;
        end
        ST_LAUNCH: begin
          major_position    <= major_start;
          minor_accumulator <= {2'b00, minor_start, {FRAC_BITS{1'b0}}};
          pixels_remaining  <= n_len + 1'b1;
          held_color        <= ld.line_color;
          line_active       <= 1'b1;
          if (n_len == '0) begin
            minor_slope <= '0;
            state       <= ST_IDLE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            minor_slope <= minor_neg ? SLOPE_BITS'(-{1'b0, div_quot[QUOT_BITS-1:0]})
                                     : {1'b0, div_quot[QUOT_BITS-1:0]};
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !is_tick) begin
      ld <= q_item;
    end
    if (state == ST_SCALE) begin
      coord[scale_idx] <= scaled[SCALED_BITS-1:0];
    end
    if (state == ST_SETUP) begin
      n_len       <= x_major ? adx : ady;
      minor_len   <= x_major ? ady : adx;
      minor_neg   <= x_major ? dy[SCALED_BITS] : dx[SCALED_BITS];
      major_start <= x_major ? coord[0] : coord[1];
      minor_start <= x_major ? coord[1] : coord[0];
    end
    if (emit) begin
      out_x     <= major_is_x ? major_position[PIX_BITS-1:0] : minor_c[PIX_BITS-1:0];
      out_y     <= major_is_x ? minor_c[PIX_BITS-1:0] : major_position[PIX_BITS-1:0];
      out_color <= held_color;
      out_last  <= rem_dec == '0;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.pixel_x     = out_x;
  assign out_ch.pixel_y     = out_y;
  assign out_ch.pixel_color = out_color;
  assign out_ch.last_pixel  = out_last;

`ifndef NO_ASSERTIONS
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (emit && rem_dec == '0) |=> !line_active)
    else $error("line still active after its last pixel");

  a_active_has_pixels: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && line_active) |-> pixels_remaining != '0)
    else $error("active line with no pixels left");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the division state");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/dda_line_rasterizer.sv
// DDA line rasterizer. A load item takes normalized endpoints and a color; it is scaled by
// the screen size registers, the major axis is chosen, and the minor slope is found by a
// bit-serial divider. While a load is set up the back end takes no other item: it does one
// scaling multiply per endpoint coordinate, then the divider gives one quotient bit per cycle.
// Each tick item then yields one pixel, at one pixel per cycle while the output is not
// stalled, with the last pixel of the line flagged; a tick with no active line gives no
// pixel. A two-entry queue between the request front end and the back end lets requests
// keep arriving while a load is set up or the pixel output is stalled.
// depends on dlr_pkg, the channel interfaces, dlr_front and dlr_back
`default_nettype none

module dda_line_rasterizer #(
  parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  dlr_cfg_if.sink   cfg_ch,
  dlr_in_if.sink    in_ch,
  dlr_out_if.source out_ch
);
  import dlr_pkg::*;

  logic [SIZE_BITS-1:0] screen_width;
  logic [SIZE_BITS-1:0] screen_height;

  dlr_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_ch.data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  dlr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  dlr_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .q_item        (q_item),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire
